FILE: sv/rc_pkg.sv
// ---------------------------------------------------------------------------
// rc_pkg - shared types and constants for the radix converter
// Field widths, register codes, state encodings and the reciprocal table
// used by the digit divider.
// ---------------------------------------------------------------------------
`default_nettype none

package rc_pkg;

   // fixed field widths
   localparam int IN_BITS     = 34;
   localparam int OUT_BITS    = 31;
   // decimal digits needed to hold any IN_BITS-wide input
   localparam int BCD_DIGITS  = 11;
   // fixed-point shift of the reciprocal table
   localparam int RECIP_SHIFT = 24;

   localparam logic [3:0] BASE_MIN          = 4'd2;
   localparam logic [3:0] BASE_MAX          = 4'd10;
   localparam logic [3:0] SOURCE_BASE_RESET = 4'd10;
   localparam logic [3:0] TARGET_BASE_RESET = 4'd2;

   typedef enum logic {
      REG_SOURCE_BASE = 1'b0,
      REG_TARGET_BASE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_BCD,
      CTL_SRC,
      CTL_DST,
      CTL_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      DST_IDLE,
      DST_MUL,
      DST_REM,
      DST_PACK
   } dst_state_type;

   // force a base register into the supported range
   function automatic logic [3:0] clamp_base(input logic [3:0] b);
      logic [3:0] res;
      res = b;
      if (b < BASE_MIN) begin
         res = BASE_MIN;
      end else if (b > BASE_MAX) begin
         res = BASE_MAX;
      end
      return res;
   endfunction

   // ceil(2^RECIP_SHIFT / b); exact quotient for values below 2^20
   function automatic logic [RECIP_SHIFT-1:0] recip_of(input logic [3:0] b);
      logic [RECIP_SHIFT-1:0] res;
      case (b)
         4'd2:    res = 24'd8388608;
         4'd3:    res = 24'd5592406;
         4'd4:    res = 24'd4194304;
         4'd5:    res = 24'd3355444;
         4'd6:    res = 24'd2796203;
         4'd7:    res = 24'd2396746;
         4'd8:    res = 24'd2097152;
         4'd9:    res = 24'd1864136;
         default: res = 24'd1677722;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: sv/rc_bcd.sv
// ---------------------------------------------------------------------------
// rc_bcd - bit-serial binary to BCD shifter
// Shifts the input word in one bit per cycle, adjusting each decimal lane
// (add three when five or more) before the shift.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_bcd
   import rc_pkg::*;
#(
   parameter int LANES = 11
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [IN_BITS-1:0]      bin,
   output logic                         done,
   output logic [LANES-1:0][3:0]        digits
);

   localparam int CW = $clog2(IN_BITS);

   logic [IN_BITS-1:0]   bin_ff;
   logic [LANES-1:0][3:0] lanes_ff, lanes_in;
   logic [LANES-1:0][3:0] adj;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // adjust every lane, then shift one bit in from the binary word
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         adj[i] = (lanes_ff[i] >= 4'd5) ? lanes_ff[i] + 4'd3 : lanes_ff[i];
      end
      lanes_in[0] = {adj[0][2:0], bin_ff[IN_BITS-1]};
      for (int i = 1; i < LANES; i++) begin
         lanes_in[i] = {adj[i][2:0], adj[i-1][3]};
      end
   end

   // control: count one step per input bit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(IN_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath: load on start, advance while busy
   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff   <= bin;
         lanes_ff <= '0;
         cnt_ff   <= '0;
      end else if (busy_ff) begin
         bin_ff   <= {bin_ff[IN_BITS-2:0], 1'b0};
         lanes_ff <= lanes_in;
         cnt_ff   <= cnt_ff + 1'b1;
      end
   end

   assign done   = done_ff;
   assign digits = lanes_ff;

endmodule

`default_nettype wire

FILE: sv/rc_src.sv
// ---------------------------------------------------------------------------
// rc_src - source digit accumulator
// Reads decimal lanes most significant first and folds them into a value
// in the source base, one digit per cycle, flagging bad digits and overflow.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_src
   import rc_pkg::*;
#(
   parameter int MAX_DIGITS = 10,
   parameter int VALUE_BITS = 10,
   parameter int LANES      = 11
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [LANES-1:0][3:0]   digits,
   input  wire logic [3:0]              base,
   output logic                         done,
   output logic [VALUE_BITS-1:0]        value,
   output logic                         err
);

   localparam int CW = $clog2(MAX_DIGITS);
   localparam int HW = VALUE_BITS + 4;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   logic [LANES-1:0][3:0]  lanes_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic                   err_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic                   hi_nz;
   logic [3:0]             dig;
   logic [HW-1:0]          horner;
   logic                   over;

   // any nonzero digit beyond the read window is an error
   always_comb begin
      hi_nz = 1'b0;
      for (int i = MAX_DIGITS; i < LANES; i++) begin
         hi_nz = hi_nz | (digits[i] != 4'd0);
      end
   end

   // one Horner step: value * base + digit
   always_comb begin
      dig    = lanes_ff[MAX_DIGITS-1];
      horner = HW'(value_ff) * HW'(base) + HW'(dig);
      over   = horner > HW'(VALUE_MAX);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(MAX_DIGITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath: saturate the value, keep the error sticky
   always_ff @(posedge clock) begin
      if (start) begin
         lanes_ff <= digits;
         value_ff <= '0;
         err_ff   <= hi_nz;
         cnt_ff   <= '0;
      end else if (busy_ff) begin
         lanes_ff <= {lanes_ff[LANES-2:0], 4'd0};
         value_ff <= over ? VALUE_MAX : horner[VALUE_BITS-1:0];
         err_ff   <= err_ff | over | (dig >= base);
         cnt_ff   <= cnt_ff + 1'b1;
      end
   end

   assign done  = done_ff;
   assign value = err_ff ? VALUE_MAX : value_ff;
   assign err   = err_ff;

endmodule

`default_nettype wire

FILE: sv/rc_dst.sv
// ---------------------------------------------------------------------------
// rc_dst - target digit generator
// Divides the value by the target base through a reciprocal multiply, one
// digit per multiply and remainder step, then packs the digits into a decimal number.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_dst
   import rc_pkg::*;
#(
   parameter int VALUE_BITS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [VALUE_BITS-1:0]   value,
   input  wire logic [3:0]              base,
   output logic                         done,
   output logic [OUT_BITS-1:0]          result
);

   localparam int CW = $clog2(VALUE_BITS);
   localparam int PW = VALUE_BITS + RECIP_SHIFT;
   localparam int QW = VALUE_BITS + 4;

   dst_state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]       v_ff;
   logic [PW-1:0]               prod_ff;
   logic [VALUE_BITS-1:0][3:0]  dig_ff;
   logic [OUT_BITS-1:0]         acc_ff;
   logic [CW-1:0]               cnt_ff;
   logic                        done_ff;
   logic                        last;
   logic                        mul_en, rem_en, pack_en;
   logic [VALUE_BITS-1:0]       quot;
   logic [QW-1:0]               qtb;
   logic [QW-1:0]               rem_full;
   logic [OUT_BITS-1:0]         acc_in;

   assign last = (cnt_ff == CW'(VALUE_BITS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DST_IDLE: if (start) state_in = DST_MUL;
         DST_MUL:  state_in = DST_REM;
         DST_REM:  state_in = last ? DST_PACK : DST_MUL;
         DST_PACK: if (last) state_in = DST_IDLE;
         default:  state_in = DST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      mul_en  = 1'b0;
      rem_en  = 1'b0;
      pack_en = 1'b0;
      unique case (state_ff)
         DST_IDLE: ;
         DST_MUL:  mul_en  = 1'b1;
         DST_REM:  rem_en  = 1'b1;
         DST_PACK: pack_en = 1'b1;
         default:  ;
      endcase
   end

   // quotient from the registered product, remainder by back-multiply
   always_comb begin
      quot     = prod_ff[PW-1:RECIP_SHIFT];
      qtb      = QW'(quot) * QW'(base);
      rem_full = QW'(v_ff) - qtb;
      acc_in   = (acc_ff << 3) + (acc_ff << 1) + OUT_BITS'(dig_ff[0]);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= pack_en && last;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (mul_en) begin
            prod_ff <= PW'(v_ff) * PW'(recip_of(base));
         end
         if (rem_en) begin
            v_ff   <= quot;
            dig_ff <= {dig_ff[VALUE_BITS-2:0], rem_full[3:0]};
            cnt_ff <= last ? '0 : cnt_ff + 1'b1;
         end
         if (pack_en) begin
            acc_ff <= acc_in;
            dig_ff <= {4'd0, dig_ff[VALUE_BITS-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

FILE: sv/radix_converter_core.sv
// Each accepted beat passes through the bit-serial BCD shifter (one input bit a cycle), the source
// digit accumulator and the reciprocal divider in turn before rsp_valid rises. req_stall stays high
// until the result is loaded into the output register, so no new beat is taken before then.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active high) returns to idle, drops rsp_valid and loads
// source_base = 10, target_base = 2.
// ---------------------------------------------------------------------------
// radix_converter_core - digit-string base converter
// Reads a decimal-coded digit string in the source base and writes the
// value back out as a decimal-coded digit string in the target base.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_converter_core
   import rc_pkg::*;
#(
   parameter int MAX_DIGITS = 10,
   parameter int VALUE_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [IN_BITS-1:0]   req_digit_string,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [OUT_BITS-1:0]       rsp_converted_digits,
   output logic                      rsp_range_error,
   // register port
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int LANES = (MAX_DIGITS > BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

   ctl_state_type           state_ff, state_in;
   logic [3:0]              source_base_ff;
   logic [3:0]              target_base_ff;
   logic                    rsp_valid_ff;
   logic [OUT_BITS-1:0]     rsp_digits_ff;
   logic                    rsp_error_ff;

   logic                    csr_write;
   reg_index_type           csr_index;
   logic [3:0]              sb, tb;

   logic                    bcd_start, bcd_done;
   logic [LANES-1:0][3:0]   bcd_digits;
   logic                    src_start, src_done, src_err;
   logic [VALUE_BITS-1:0]   src_value;
   logic                    dst_start, dst_done;
   logic [OUT_BITS-1:0]     dst_result;
   logic                    out_free;
   logic                    out_load;

   // register port: writes land on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         source_base_ff <= SOURCE_BASE_RESET;
         target_base_ff <= TARGET_BASE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SOURCE_BASE: source_base_ff <= csr_pwdata[3:0];
            REG_TARGET_BASE: target_base_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SOURCE_BASE: csr_prdata = {28'd0, source_base_ff};
         REG_TARGET_BASE: csr_prdata = {28'd0, target_base_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign sb = clamp_base(source_base_ff);
   assign tb = clamp_base(target_base_ff);

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: if (req_valid) state_in = CTL_BCD;
         CTL_BCD:  if (bcd_done)  state_in = CTL_SRC;
         CTL_SRC:  if (src_done)  state_in = CTL_DST;
         CTL_DST:  if (dst_done)  state_in = CTL_OUT;
         CTL_OUT:  if (out_free)  state_in = CTL_IDLE;
         default:  state_in = CTL_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      bcd_start = 1'b0;
      src_start = 1'b0;
      dst_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            bcd_start = req_valid;
         end
         CTL_BCD:  src_start = bcd_done;
         CTL_SRC:  dst_start = src_done;
         CTL_DST:  ;
         CTL_OUT:  out_load  = out_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register: hold until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_digits_ff <= dst_result;
         rsp_error_ff  <= src_err;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_converted_digits = rsp_digits_ff;
   assign rsp_range_error      = rsp_error_ff;

   rc_bcd #(
      .LANES (LANES)
   ) u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .bin    (req_digit_string),
      .done   (bcd_done),
      .digits (bcd_digits)
   );

   rc_src #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS),
      .LANES      (LANES)
   ) u_src (
      .clock  (clock),
      .reset  (reset),
      .start  (src_start),
      .digits (bcd_digits),
      .base   (sb),
      .done   (src_done),
      .value  (src_value),
      .err    (src_err)
   );

   rc_dst #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dst (
      .clock  (clock),
      .reset  (reset),
      .start  (dst_start),
      .value  (src_value),
      .base   (tb),
      .done   (dst_done),
      .result (dst_result)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_radix_converter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_radix_converter_core - self-checking bench for the radix converter
// Drives digit strings through the valid/stall input channel, predicts each
// conversion from its own copy of the two base registers, and checks every
// result beat field by field. Base registers are changed over the register
// port between phases, once the core has drained.
// ---------------------------------------------------------------------------

module tb_radix_converter_core
   import rc_pkg::*;
();

   localparam int MAX_DIGITS = 10;
   localparam int VALUE_BITS = 10;
   localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
   localparam longint unsigned TEN_DIGITS = 64'd10000000000;
   localparam int IDLE_PCT = 16;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 125;
   // room for every beat plus idling, taken several times over
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [IN_BITS-1:0]  source;
      logic [OUT_BITS-1:0] digits;
      logic                err;
   } conversion_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [IN_BITS-1:0]  req_digit_string;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [OUT_BITS-1:0] rsp_converted_digits;
   logic                rsp_range_error;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   logic [IN_BITS-1:0] pending_strings[$];
   conversion_type     expected_conversions[$];
   logic [3:0]         source_base_reg;
   logic [3:0]         target_base_reg;
   logic               req_taken;
   logic               quiet;
   int unsigned        mismatch_count;
   int unsigned        cycle_count;

   radix_converter_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_digit_string     (req_digit_string),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_converted_digits (rsp_converted_digits),
      .rsp_range_error      (rsp_range_error),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR: %s", msg);
   endtask

   // Bring a base register into 2..10
   function automatic int unsigned usable_base(input logic [3:0] b);
      int unsigned res;
      res = b;
      if (res < 2) begin
         res = 2;
      end else if (res > 10) begin
         res = 10;
      end
      return res;
   endfunction

   // Write a value as decimal-coded digits of the given base
   function automatic longint unsigned spell_in_base(input longint unsigned value,
                                                     input int unsigned base);
      longint unsigned acc;
      longint unsigned place;
      acc = 0;
      place = 1;
      for (int i = 0; i < VALUE_BITS && value != 0; i++) begin
         acc += (value % base) * place;
         value /= base;
         place *= 10;
      end
      return acc;
   endfunction

   // Expected conversion of one digit string under the current bases
   function automatic conversion_type convert_string(input logic [IN_BITS-1:0] ds);
      longint unsigned rest;
      longint unsigned value;
      longint unsigned weight;
      longint unsigned digit;
      longint unsigned spelled;
      int unsigned     sb;
      int unsigned     tb;
      conversion_type  res;
      sb = usable_base(source_base_reg);
      tb = usable_base(target_base_reg);
      rest = ds;
      value = 0;
      weight = 1;
      res.source = ds;
      res.err = 1'b0;
      // peel the low digits, then any digit above them is an error
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digit = rest % 10;
         rest /= 10;
         if (digit >= sb) begin
            res.err = 1'b1;
         end
         value += digit * weight;
         weight *= sb;
      end
      if (rest != 0 || value > VALUE_MAX) begin
         res.err = 1'b1;
      end
      if (res.err) begin
         value = VALUE_MAX;
      end
      spelled = spell_in_base(value, tb);
      res.digits = spelled[OUT_BITS-1:0];
      return res;
   endfunction

   // Mostly well-formed strings in the source base, the rest broken or noise
   function automatic logic [IN_BITS-1:0] make_digit_string();
      int unsigned     sb;
      int unsigned     pos;
      longint unsigned value;
      longint unsigned top;
      longint unsigned place;
      longint unsigned old_digit;
      logic [63:0]     noise;
      sb = usable_base(source_base_reg);
      top = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         top *= sb;
      end
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
            if ($urandom_range(7) == 0) begin
               value = $urandom_range(1) ? VALUE_MAX : 0;
            end else begin
               value = $urandom_range(VALUE_MAX);
            end
            value = spell_in_base(value, sb);
         end
         11, 12: begin
            // well formed but past the value range
            if (top > VALUE_MAX + 1) begin
               value = spell_in_base(VALUE_MAX + 1 + ($urandom() % (top - VALUE_MAX - 1)), sb);
            end else begin
               value = spell_in_base($urandom_range(VALUE_MAX), sb);
            end
         end
         13, 14, 15: begin
            // every position a legal digit
            value = 0;
            place = 1;
            for (int i = 0; i < MAX_DIGITS; i++) begin
               value += $urandom_range(sb - 1) * place;
               place *= 10;
            end
         end
         16: begin
            // one digit not below the source base
            value = spell_in_base($urandom_range(VALUE_MAX), sb);
            if (sb < 10) begin
               pos = $urandom_range(MAX_DIGITS - 1);
               place = 1;
               for (int i = 0; i < pos; i++) begin
                  place *= 10;
               end
               old_digit = (value / place) % 10;
               value = value - old_digit * place + $urandom_range(9, sb) * place;
            end
         end
         17: begin
            // nonzero digit past the last one read
            value = TEN_DIGITS + spell_in_base($urandom_range(VALUE_MAX), sb);
            if ($urandom_range(1)) begin
               value = TEN_DIGITS + $urandom();
            end
         end
         default: begin
            noise = {$urandom(), $urandom()};
            value = noise[IN_BITS-1:0];
         end
      endcase
      return value[IN_BITS-1:0];
   endfunction

   task automatic load(input longint unsigned ds);
      pending_strings.push_back(ds[IN_BITS-1:0]);
   endtask

   // Write one base register, then read it back
   task automatic write_base(input reg_index_type idx, input logic [3:0] base);
      logic [31:0] wdata;
      logic [31:0] rdata;
      wdata = $urandom();
      if ($urandom_range(1)) begin
         wdata[31:4] = '0;
      end
      wdata[3:0] = base;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_SOURCE_BASE) begin
         source_base_reg = base;
      end else begin
         target_base_reg = base;
      end
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata[3:0] !== base) begin
         report_mismatch($sformatf("register %s reads %0h, wrote %0h",
                                   idx.name(), rdata[3:0], base));
      end
   endtask

   task automatic set_bases(input logic [3:0] src, input logic [3:0] dst);
      write_base(REG_SOURCE_BASE, src);
      write_base(REG_TARGET_BASE, dst);
      @(posedge clock);
   endtask

   // Hold until the sender has nothing left and every result is back;
   // sample on the rising edge, where the sender's queue and valid are settled
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_strings.size() != 0 || req_valid || expected_conversions.size() != 0);
   endtask

   // Sender: hold a stalled beat, otherwise offer the next string or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_strings.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               req_digit_string <= pending_strings.pop_front();
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Predict on each accepted beat, check each result beat
   always @(posedge clock) begin
      conversion_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_conversions.push_back(convert_string(req_digit_string));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_conversions.size() == 0) begin
               report_mismatch($sformatf("result %0d err %0b with nothing pending",
                                         rsp_converted_digits, rsp_range_error));
            end else begin
               want = expected_conversions.pop_front();
               if (rsp_converted_digits !== want.digits) begin
                  report_mismatch($sformatf("input %0d: digits %0d, want %0d",
                                            want.source, rsp_converted_digits, want.digits));
               end
               if (rsp_range_error !== want.err) begin
                  report_mismatch($sformatf("input %0d: range_error %0b, want %0b",
                                            want.source, rsp_range_error, want.err));
               end
            end
         end
      end
   end

   // Guard against a hung core
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_digit_string = '0;
      rsp_stall        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_taken        = 1'b0;
      quiet            = 1'b0;
      mismatch_count   = 0;
      cycle_count      = 0;
      source_base_reg  = SOURCE_BASE_RESET;
      target_base_reg  = TARGET_BASE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset bases: decimal in, binary out
      load(0);
      load(1);
      load(5);
      load(VALUE_MAX);
      load(VALUE_MAX + 1);
      load(64'd9999999999);
      load((64'd1 << IN_BITS) - 1);
      load(TEN_DIGITS);
      wait_drained();

      // decimal to decimal passes through; 1100 is past the value range
      set_bases(4'd10, 4'd10);
      load(987);
      load(0);
      load(1023);
      load(1100);
      wait_drained();

      // binary in: all ones, bad digit, small values
      set_bases(4'd2, 4'd10);
      load(64'd1111111111);
      load(64'd1111111112);
      load(10);
      load(101);
      load(2);
      wait_drained();

      // out-of-range registers clamp
      set_bases(4'd0, 4'd15);
      load(64'd1010101010);
      load(11);
      wait_drained();
      set_bases(4'd15, 4'd1);
      load(1000);
      load(7);
      wait_drained();

      set_bases(4'd9, 4'd9);
      load(1358);
      load(1357);
      load(888);
      wait_drained();
      set_bases(4'd8, 4'd3);
      load(1777);
      load(7777);
      wait_drained();

      // random phases, extremes first; one phase runs with no idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       set_bases(4'd2, 4'd2);
            1:       set_bases(4'd10, 4'd10);
            2:       set_bases(4'd2, 4'd10);
            3:       set_bases(4'd10, 4'd2);
            4:       set_bases(4'd0, 4'd0);
            5:       set_bases(4'd15, 4'd15);
            default: begin
               set_bases(4'($urandom_range(99) < 85 ? $urandom_range(10, 2)
                                                     : $urandom_range(15)),
                         4'($urandom_range(99) < 85 ? $urandom_range(10, 2)
                                                     : $urandom_range(15)));
            end
         endcase
         quiet = (p == 7);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_strings.push_back(make_digit_string());
         end
         wait_drained();
      end
      quiet = 1'b0;

      // let any stray result show up
      repeat (100) @(posedge clock);
      if (expected_conversions.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_conversions.size()));
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
